// ===== hw/rtl/vr_pkg.sv =====
package vr_pkg;

  localparam int unsigned FRAC        = 16;
  localparam int unsigned IN_W        = 18;
  localparam int unsigned RAT_W       = 20;
  localparam int unsigned OUT_W       = 20;
  localparam int unsigned CS_W        = 22;
  localparam int unsigned PERP_W      = 28;
  localparam int unsigned WIDE_W      = 56;
  localparam int unsigned ROOT_W      = 28;
  localparam int unsigned SQ_STEPS    = 27;
  localparam int unsigned FIFO_DEPTH  = 4;
  localparam int unsigned FIFO_AW     = 2;
  localparam int unsigned FIFO_CW     = 3;
  localparam int unsigned IN_DATA_W   = 128;
  localparam int unsigned OUT_DATA_W  = 64;

  // Back pipeline: six arithmetic stages, the root steps, then root, product, output.
  localparam int unsigned ST_DIFF     = 5;
  localparam int unsigned ST_SQ0      = 6;
  localparam int unsigned ST_ROOT     = ST_SQ0 + SQ_STEPS;
  localparam int unsigned ST_PROD     = ST_ROOT + 1;
  localparam int unsigned BACK_STAGES = ST_PROD + 2;

  typedef logic [IN_W-1:0] comp_t;

  // One classified item as it waits between the front and the back.
  typedef struct packed {
    comp_t [2:0]              inc;
    comp_t [2:0]              nrm;
    logic [RAT_W-1:0]         ratio;
    logic signed [CS_W-1:0]   cs;
  } item_t;

  typedef struct packed {
    logic               full;
    logic               empty;
    logic [FIFO_CW-1:0] count;
  } fifo_stat_t;

endpackage

// ===== hw/rtl/vr_front.sv =====
module vr_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  logic [vr_pkg::IN_DATA_W-1:0] data_i,
  input  logic                        full_i,
  output logic                        push_o,
  output vr_pkg::item_t               item_o
);
  import vr_pkg::*;

  localparam int unsigned PW = 2 * IN_W;
  localparam int unsigned DW = PW + 2;
  localparam logic signed [DW-1:0] ONE  = DW'(64'd1 << (2 * FRAC));
  localparam logic signed [DW-1:0] HALF = DW'(64'd1 << (FRAC - 1));

  logic                 v1_q, v2_q, en;
  comp_t [2:0]          inc1_q, nrm1_q;
  logic [RAT_W-1:0]     rat1_q;
  logic signed [PW-1:0] prod_q [3];
  item_t                item_q;
  logic signed [DW-1:0] dsum, ndot, ndot_c, ndot_r;

  assign en      = !v2_q || !full_i;
  assign ready_o = en;
  assign push_o  = v2_q && !full_i;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        inc1_q[i] <= data_i[i*IN_W +: IN_W];
        nrm1_q[i] <= data_i[(3+i)*IN_W +: IN_W];
        prod_q[i] <= $signed(data_i[i*IN_W +: IN_W]) * $signed(data_i[(3+i)*IN_W +: IN_W]);
      end
      rat1_q       <= data_i[6*IN_W +: RAT_W];
      item_q.inc   <= inc1_q;
      item_q.nrm   <= nrm1_q;
      item_q.ratio <= rat1_q;
      item_q.cs    <= ndot_r[DW-1 -: CS_W];
    end
  end

  // Cosine: negated dot product, limited to one, rounded half up.
  always_comb begin
    dsum   = DW'(prod_q[0]) + DW'(prod_q[1]) + DW'(prod_q[2]);
    ndot   = -dsum;
    ndot_c = (ndot > ONE) ? ONE : ndot;
    ndot_r = ndot_c + HALF;
  end

endmodule

// ===== hw/rtl/vr_fifo.sv =====
module vr_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  vr_pkg::item_t      item_i,
  input  logic               pop_i,
  output vr_pkg::item_t      item_o,
  output vr_pkg::fifo_stat_t stat_o
);
  import vr_pkg::*;

  item_t                mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_q, rd_q;
  logic [FIFO_CW-1:0]   cnt_q;

  assign item_o       = mem_q[rd_q];
  assign stat_o.count = cnt_q;
  assign stat_o.full  = (cnt_q == FIFO_CW'(FIFO_DEPTH));
  assign stat_o.empty = (cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= item_i;
  end

endmodule

// ===== hw/rtl/vr_back.sv =====
module vr_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          empty_i,
  input  vr_pkg::item_t                 item_i,
  output logic                          pop_o,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [vr_pkg::OUT_DATA_W-1:0] data_o,
  output logic                          clip_o
);
  import vr_pkg::*;

  localparam int unsigned NC_W = IN_W + CS_W;
  localparam int unsigned T_W  = NC_W - FRAC + 1;
  localparam int unsigned TR_W = T_W + RAT_W + 1;
  localparam int unsigned PR_W = IN_W + ROOT_W + 1;
  localparam int unsigned NG_W = PR_W + 1;
  localparam int unsigned PA_W = NG_W - FRAC;
  localparam int unsigned SM_W = PA_W + 1;
  localparam logic [WIDE_W-1:0] ONE_U = WIDE_W'(64'd1 << (2 * FRAC));
  localparam logic signed [SM_W-1:0] OMAX = SM_W'((64'd1 << (OUT_W - 1)) - 1);
  localparam logic signed [SM_W-1:0] OMIN = -SM_W'(64'd1 << (OUT_W - 1));

  typedef struct packed {
    comp_t [2:0]                 nrm;
    logic signed [2:0][PERP_W-1:0] perp;
  } carry_t;

  logic                      en;
  logic [BACK_STAGES-1:0]    v_q;
  carry_t                    car_q [BACK_STAGES];
  comp_t [2:0]               inc0_q;
  logic [RAT_W-1:0]          rat_q [2];
  logic signed [NC_W-1:0]    nc_q [3];
  logic signed [T_W-1:0]     t_q [3];
  logic signed [TR_W-1:0]    tr_q [3];
  logic [WIDE_W-1:0]         sq_q [3];
  logic [WIDE_W-1:0]         sn_q [SQ_STEPS+1];
  logic [WIDE_W-1:0]         sr_q [SQ_STEPS+1];
  logic [ROOT_W-1:0]         root_q;
  logic signed [PR_W-1:0]    pr_q [3];
  logic [OUT_W-1:0]          out_q [3];
  logic                      clip_q;
  logic [WIDE_W-1:0]         lsq;

  assign en      = !v_q[BACK_STAGES-1] || ready_i;
  assign pop_o   = !empty_i && en;
  assign valid_o = v_q[BACK_STAGES-1];
  assign clip_o  = clip_q;
  assign data_o  = {(OUT_DATA_W - 3*OUT_W)'(0), out_q[2], out_q[1], out_q[0]};
  assign lsq     = sq_q[0] + sq_q[1] + sq_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[BACK_STAGES-2:0], pop_o};
    end
  end

  // One restoring square-root step per stage; stage k tests bit 4^(26-k).
  always_ff @(posedge clk_i) begin
    logic [WIDE_W-1:0] bitv, trial;
    logic signed [NC_W-1:0] ncr;
    logic signed [TR_W-1:0] trr;
    logic signed [NG_W-1:0] ng;
    logic signed [SM_W-1:0] sm;
    logic              clip;
    if (en) begin
      car_q[0].nrm  <= item_i.nrm;
      car_q[0].perp <= '0;
      for (int j = 1; j < BACK_STAGES; j++) begin
        car_q[j].nrm <= car_q[j-1].nrm;
        if (j != 3) car_q[j].perp <= car_q[j-1].perp;
      end
      inc0_q <= item_i.inc;
      rat_q[0] <= item_i.ratio;
      rat_q[1] <= rat_q[0];
      for (int i = 0; i < 3; i++) begin
        nc_q[i] <= $signed(item_i.nrm[i]) * item_i.cs;
        ncr     = nc_q[i] + NC_W'(64'd1 << (FRAC - 1));
        t_q[i]  <= T_W'($signed(inc0_q[i])) + T_W'($signed(ncr[NC_W-1:FRAC]));
        tr_q[i] <= t_q[i] * $signed({1'b0, rat_q[1]});
        trr     = tr_q[i] + TR_W'(64'd1 << (FRAC - 1));
        car_q[3].perp[i] <= trr[FRAC +: PERP_W];
        sq_q[i] <= WIDE_W'($signed(car_q[3].perp[i]) * $signed(car_q[3].perp[i]));
      end
      sn_q[0] <= (lsq >= ONE_U) ? (lsq - ONE_U) : (ONE_U - lsq);
      sr_q[0] <= '0;
      for (int k = 0; k < SQ_STEPS; k++) begin
        bitv  = WIDE_W'(1) << (2 * (SQ_STEPS - 1 - k));
        trial = sr_q[k] + bitv;
        if (sn_q[k] >= trial) begin
          sn_q[k+1] <= sn_q[k] - trial;
          sr_q[k+1] <= (sr_q[k] >> 1) + bitv;
        end else begin
          sn_q[k+1] <= sn_q[k];
          sr_q[k+1] <= sr_q[k] >> 1;
        end
      end
      root_q <= ROOT_W'(sr_q[SQ_STEPS]) + ROOT_W'(sn_q[SQ_STEPS] > sr_q[SQ_STEPS]);
      clip = 1'b0;
      for (int i = 0; i < 3; i++) begin
        pr_q[i] <= $signed(car_q[ST_ROOT].nrm[i]) * $signed({1'b0, root_q});
        ng = -NG_W'(pr_q[i]) + NG_W'(64'd1 << (FRAC - 1));
        sm = SM_W'($signed(car_q[ST_PROD].perp[i])) + SM_W'($signed(ng[NG_W-1:FRAC]));
        if (sm > OMAX) begin
          out_q[i] <= OMAX[OUT_W-1:0];
          clip = 1'b1;
        end else if (sm < OMIN) begin
          out_q[i] <= OMIN[OUT_W-1:0];
          clip = 1'b1;
        end else begin
          out_q[i] <= sm[OUT_W-1:0];
        end
      end
      clip_q <= clip;
    end
  end

endmodule

// ===== hw/rtl/vector_refraction.sv =====
// Vector refraction by Snell's law: each item carries a unit incident
// direction and surface normal (signed Q2.16) and an index ratio (unsigned
// Q4.16), and yields the refracted direction in signed Q4.16, saturated, with
// a flag in tuser that is set when any output component was saturated. The
// block accepts one item per cycle while the queue has room and returns one
// result per item, in order. An item is worked in the front, which forms the
// cosine, then waits in the four-entry queue, and is finished in the back,
// whose square-root pipeline resolves one bit per stage. The front keeps
// accepting while the queue has room, so a stalled output holds the back
// pipeline without at once blocking the input.
module vector_refraction (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // inc_x, inc_y, inc_z, nrm_x, nrm_y, nrm_z, index_ratio from bit 0 upwards
  input  logic [vr_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // out_x, out_y, out_z from bit 0 upwards, then zero padding
  output logic [vr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // clipped
  output logic                          m_axis_tuser
);
  import vr_pkg::*;

  logic       push, pop;
  item_t      push_item, head_item;
  fifo_stat_t fstat;

  vr_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .data_i  (s_axis_tdata),
    .full_i  (fstat.full),
    .push_o  (push),
    .item_o  (push_item)
  );

  vr_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .pop_i  (pop),
    .item_o (head_item),
    .stat_o (fstat)
  );

  vr_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (fstat.empty),
    .item_i  (head_item),
    .pop_o   (pop),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (m_axis_tdata),
    .clip_o  (m_axis_tuser)
  );

  // The queue never holds more items than it has entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fstat.count <= FIFO_CW'(FIFO_DEPTH))
    else $error("queue count beyond depth");

  // The input is only held off when the queue is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> fstat.full)
    else $error("input stalled with room in the queue");

  // A saturated result must sit on a rail in at least one component.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |->
      (m_axis_tdata[19:0] == 20'h7FFFF || m_axis_tdata[19:0] == 20'h80000 ||
       m_axis_tdata[39:20] == 20'h7FFFF || m_axis_tdata[39:20] == 20'h80000 ||
       m_axis_tdata[59:40] == 20'h7FFFF || m_axis_tdata[59:40] == 20'h80000))
    else $error("clip flag without a saturated component");

endmodule
